// ===== rtl/thbf_pkg.sv =====
// Package for the three-hash Bloom filter core.
// Holds the item types, command codes, hash step codes and hash seeds.
// Used by the core, hash and remainder modules and the testbench; depends on nothing.
`default_nettype none

package thbf_pkg;

	localparam int HASH_W = 64;
	localparam int SIZE_W = 11;
	localparam int IDX_W  = 10;
	localparam int STEP_W = 4;

	localparam logic [HASH_W-1:0] DJB_SEED = 64'd5381;
	localparam logic [HASH_W-1:0] FNV_SEED = 64'h0000_0000_811c_9dc5;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_QUERY  = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	localparam logic [STEP_W-1:0] HS_HOLD     = 4'd0;
	localparam logic [STEP_W-1:0] HS_RELOAD   = 4'd1;
	localparam logic [STEP_W-1:0] HS_DJB      = 4'd2;
	localparam logic [STEP_W-1:0] HS_OAAT_ADD = 4'd3;
	localparam logic [STEP_W-1:0] HS_OAAT_MIX = 4'd4;
	localparam logic [STEP_W-1:0] HS_FNV_XOR  = 4'd5;
	localparam logic [STEP_W-1:0] HS_FNV_4    = 4'd6;
	localparam logic [STEP_W-1:0] HS_FNV_7    = 4'd7;
	localparam logic [STEP_W-1:0] HS_FNV_8    = 4'd8;
	localparam logic [STEP_W-1:0] HS_FNV_24   = 4'd9;
	localparam logic [STEP_W-1:0] HS_FIN_A    = 4'd10;
	localparam logic [STEP_W-1:0] HS_FIN_B    = 4'd11;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] key_byte;
		logic       has_byte;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic              maybe_present;
		logic [IDX_W-1:0]  index_one;
		logic [IDX_W-1:0]  index_two;
		logic [IDX_W-1:0]  index_three;
		logic [SIZE_W-1:0] bits_set;
		logic              over_loaded;
	} out_item_t;

	typedef struct packed {
		logic [STEP_W-1:0] step;
		logic [7:0]        key_byte;
	} hash_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/three_hash_bloom_filter_core.sv =====
// Three-hash Bloom filter core: sequencer, size register, set count and results.
// Depends on thbf_pkg, thbf_hash_alu, thbf_mod_unit and thbf_bit_store.
// A key byte keeps busy high while it steps on the shared 64-bit adder. A last item
// then runs the final mix, the 64-step remainder unit and three store reads; its
// result strobes as busy falls. A clear sweeps the store, writing zero to every bit.
// After reset the same sweep runs before the first item is taken.
`default_nettype none

module three_hash_bloom_filter_core
	import thbf_pkg::*;
#(
	parameter int FILTER_BITS = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire in_item_t          item,
	input  wire logic              cfg_wen,
	input  wire logic [SIZE_W-1:0] cfg_wdata,
	output logic                   result_valid,
	output out_item_t              result
);

	localparam int AW = $clog2(FILTER_BITS);
	localparam int CW = $clog2(FILTER_BITS + 1);
	localparam int LW = (CW + 4 > SIZE_W + 3) ? CW + 4 : SIZE_W + 3;

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_CLR    = 5'd1;
	localparam logic [4:0] S_DJB    = 5'd2;
	localparam logic [4:0] S_OA1    = 5'd3;
	localparam logic [4:0] S_OA2    = 5'd4;
	localparam logic [4:0] S_F1     = 5'd5;
	localparam logic [4:0] S_F4     = 5'd6;
	localparam logic [4:0] S_F7     = 5'd7;
	localparam logic [4:0] S_F8     = 5'd8;
	localparam logic [4:0] S_F24    = 5'd9;
	localparam logic [4:0] S_FINA   = 5'd10;
	localparam logic [4:0] S_FINB   = 5'd11;
	localparam logic [4:0] S_MSTART = 5'd12;
	localparam logic [4:0] S_MWAIT  = 5'd13;
	localparam logic [4:0] S_RD     = 5'd14;
	localparam logic [4:0] S_CHK    = 5'd15;
	localparam logic [4:0] S_OUT    = 5'd16;

	logic [4:0]        state_q;
	logic [SIZE_W-1:0] filter_size_q;
	logic [SIZE_W-1:0] size_q;
	logic [7:0]        byte_q;
	logic              last_q;
	logic              insert_q;
	logic              clr_report_q;
	logic [AW-1:0]     clr_cnt_q;
	logic [CW-1:0]     count_q;
	logic [1:0]        k_q;
	logic              present_q;
	logic              result_valid_q;
	out_item_t         result_q;

	logic [SIZE_W-1:0] live_size;
	hash_ctl_t         hctl;
	logic [HASH_W-1:0] djb;
	logic [HASH_W-1:0] oaat;
	logic [HASH_W-1:0] fnv;
	logic              mod_done;
	logic [SIZE_W-1:0] rem_one;
	logic [SIZE_W-1:0] rem_two;
	logic [SIZE_W-1:0] rem_three;
	logic [SIZE_W-1:0] rem_sel;
	logic              rd_data;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic              wr_data;
	logic              over;

	always_comb begin
		live_size = filter_size_q;
		if (filter_size_q == '0) begin
			live_size = SIZE_W'(1);
		end else if ({21'b0, filter_size_q} > 32'(FILTER_BITS)) begin
			live_size = SIZE_W'(FILTER_BITS);
		end
	end

	always_comb begin
		hctl.key_byte = byte_q;
		case (state_q)
			S_IDLE:   hctl.step = (start && item.cmd == CMD_CLEAR) ? HS_RELOAD : HS_HOLD;
			S_DJB:    hctl.step = HS_DJB;
			S_OA1:    hctl.step = HS_OAAT_ADD;
			S_OA2:    hctl.step = HS_OAAT_MIX;
			S_F1:     hctl.step = HS_FNV_XOR;
			S_F4:     hctl.step = HS_FNV_4;
			S_F7:     hctl.step = HS_FNV_7;
			S_F8:     hctl.step = HS_FNV_8;
			S_F24:    hctl.step = HS_FNV_24;
			S_FINA:   hctl.step = HS_FIN_A;
			S_FINB:   hctl.step = HS_FIN_B;
			S_MSTART: hctl.step = HS_RELOAD;
			default:  hctl.step = HS_HOLD;
		endcase
	end

	always_comb begin
		case (k_q)
			2'd0:    rem_sel = rem_one;
			2'd1:    rem_sel = rem_two;
			default: rem_sel = rem_three;
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = AW'(rem_sel);
		wr_data = 1'b1;
		if (state_q == S_CLR) begin
			wr_en   = 1'b1;
			wr_addr = clr_cnt_q;
			wr_data = 1'b0;
		end else if (state_q == S_CHK) begin
			wr_en = insert_q && !rd_data;
		end
	end

	assign over = ((LW'(count_q) << 3) + (LW'(count_q) << 1)) >
		((LW'(size_q) << 3) - LW'(size_q));

	thbf_hash_alu u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (hctl),
		.djb    (djb),
		.oaat   (oaat),
		.fnv    (fnv)
	);

	thbf_mod_unit u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (state_q == S_MSTART),
		.size      (size_q),
		.val_one   (djb),
		.val_two   (oaat),
		.val_three (fnv),
		.rem_one   (rem_one),
		.rem_two   (rem_two),
		.rem_three (rem_three),
		.done      (mod_done)
	);

	thbf_bit_store #(
		.DEPTH (FILTER_BITS)
	) u_store (
		.clk     (clk),
		.rd_en   (state_q == S_RD),
		.rd_addr (AW'(rem_sel)),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_size_q <= SIZE_W'(1024);
		end else if (cfg_wen) begin
			filter_size_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_CLR;
			size_q         <= SIZE_W'(1);
			byte_q         <= '0;
			last_q         <= 1'b0;
			insert_q       <= 1'b0;
			clr_report_q   <= 1'b0;
			clr_cnt_q      <= '0;
			count_q        <= '0;
			k_q            <= '0;
			present_q      <= 1'b0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			result_valid_q <= (state_q == S_OUT) || ((state_q == S_CLR) && clr_report_q &&
				(clr_cnt_q == AW'(FILTER_BITS - 1)));
			case (state_q)
				S_CLR: begin
					if (clr_cnt_q == AW'(FILTER_BITS - 1)) begin
						clr_cnt_q    <= '0;
						clr_report_q <= 1'b0;
						state_q      <= S_IDLE;
						if (clr_report_q) begin
							result_q <= '0;
						end
					end else begin
						clr_cnt_q <= clr_cnt_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (start) begin
						case (item.cmd)
							CMD_INSERT, CMD_QUERY: begin
								byte_q   <= item.key_byte;
								last_q   <= item.last;
								insert_q <= (item.cmd == CMD_INSERT);
								if (item.has_byte) begin
									state_q <= S_DJB;
								end else if (item.last) begin
									state_q <= S_FINA;
								end
							end
							CMD_CLEAR: begin
								clr_report_q <= 1'b1;
								clr_cnt_q    <= '0;
								count_q      <= '0;
								state_q      <= S_CLR;
							end
							default: begin
							end
						endcase
					end
				end
				S_DJB:  state_q <= S_OA1;
				S_OA1:  state_q <= S_OA2;
				S_OA2:  state_q <= S_F1;
				S_F1:   state_q <= S_F4;
				S_F4:   state_q <= S_F7;
				S_F7:   state_q <= S_F8;
				S_F8:   state_q <= S_F24;
				S_F24:  state_q <= last_q ? S_FINA : S_IDLE;
				S_FINA: state_q <= S_FINB;
				S_FINB: state_q <= S_MSTART;
				S_MSTART: begin
					size_q  <= live_size;
					state_q <= S_MWAIT;
				end
				S_MWAIT: begin
					if (mod_done) begin
						k_q       <= '0;
						present_q <= 1'b1;
						state_q   <= S_RD;
					end
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					present_q <= present_q & rd_data;
					if (insert_q && !rd_data) begin
						count_q <= count_q + CW'(1);
					end
					if (k_q == 2'd2) begin
						state_q <= S_OUT;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= S_RD;
					end
				end
				S_OUT: begin
					result_q.maybe_present <= present_q;
					result_q.index_one     <= rem_one[IDX_W-1:0];
					result_q.index_two     <= rem_two[IDX_W-1:0];
					result_q.index_three   <= rem_three[IDX_W-1:0];
					result_q.bits_set      <= SIZE_W'(count_q);
					result_q.over_loaded   <= over;
					state_q                <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

// ===== rtl/thbf_hash_alu.sv =====
// Three running 64-bit hashes updated through one shared adder.
// Each step code selects the operands and the write-back of one hash; reload restores all three seeds.
// Depends on thbf_pkg.
`default_nettype none

module thbf_hash_alu
	import thbf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire hash_ctl_t         ctl,
	output logic [HASH_W-1:0]      djb,
	output logic [HASH_W-1:0]      oaat,
	output logic [HASH_W-1:0]      fnv
);

	logic [HASH_W-1:0] djb_q;
	logic [HASH_W-1:0] oaat_q;
	logic [HASH_W-1:0] fnv_q;
	logic [HASH_W-1:0] acc_q;
	logic [HASH_W-1:0] opa;
	logic [HASH_W-1:0] opb;
	logic [7:0]        add_byte;
	logic [HASH_W-1:0] sum;
	logic [HASH_W-1:0] fnv_x;

	always_comb begin
		fnv_x    = fnv_q ^ {{(HASH_W-8){1'b0}}, ctl.key_byte};
		opa      = '0;
		opb      = '0;
		add_byte = '0;
		case (ctl.step)
			HS_DJB: begin
				opa      = djb_q << 5;
				opb      = djb_q;
				add_byte = ctl.key_byte;
			end
			HS_OAAT_ADD: begin
				opa      = oaat_q;
				add_byte = ctl.key_byte;
			end
			HS_OAAT_MIX: begin
				opa = oaat_q;
				opb = oaat_q << 10;
			end
			HS_FNV_XOR: begin
				opa = fnv_x;
				opb = fnv_x << 1;
			end
			HS_FNV_4: begin
				opa = acc_q;
				opb = fnv_q << 4;
			end
			HS_FNV_7: begin
				opa = acc_q;
				opb = fnv_q << 7;
			end
			HS_FNV_8: begin
				opa = acc_q;
				opb = fnv_q << 8;
			end
			HS_FNV_24: begin
				opa = acc_q;
				opb = fnv_q << 24;
			end
			HS_FIN_A: begin
				opa = oaat_q;
				opb = oaat_q << 3;
			end
			HS_FIN_B: begin
				opa = oaat_q;
				opb = oaat_q << 15;
			end
			default: begin
				opa = '0;
			end
		endcase
		sum = opa + opb + {{(HASH_W-8){1'b0}}, add_byte};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			djb_q  <= DJB_SEED;
			oaat_q <= '0;
			fnv_q  <= FNV_SEED;
			acc_q  <= '0;
		end else begin
			case (ctl.step)
				HS_RELOAD: begin
					djb_q  <= DJB_SEED;
					oaat_q <= '0;
					fnv_q  <= FNV_SEED;
				end
				HS_DJB:      djb_q  <= sum;
				HS_OAAT_ADD: oaat_q <= sum;
				HS_OAAT_MIX: oaat_q <= sum ^ (sum >> 6);
				HS_FNV_XOR: begin
					fnv_q <= fnv_x;
					acc_q <= sum;
				end
				HS_FNV_4:    acc_q  <= sum;
				HS_FNV_7:    acc_q  <= sum;
				HS_FNV_8:    acc_q  <= sum;
				HS_FNV_24:   fnv_q  <= sum;
				HS_FIN_A:    oaat_q <= sum ^ (sum >> 11);
				HS_FIN_B:    oaat_q <= sum;
				default: begin
				end
			endcase
		end
	end

	assign djb  = djb_q;
	assign oaat = oaat_q;
	assign fnv  = fnv_q;

endmodule

`default_nettype wire

// ===== rtl/thbf_mod_unit.sv =====
// Bit-serial remainder unit: reduces three 64-bit hashes modulo the size.
// One restoring step per lane and cycle, one step per hash bit.
// Depends on thbf_pkg.
`default_nettype none

module thbf_mod_unit
	import thbf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [SIZE_W-1:0] size,
	input  wire logic [HASH_W-1:0] val_one,
	input  wire logic [HASH_W-1:0] val_two,
	input  wire logic [HASH_W-1:0] val_three,
	output logic [SIZE_W-1:0]      rem_one,
	output logic [SIZE_W-1:0]      rem_two,
	output logic [SIZE_W-1:0]      rem_three,
	output logic                   done
);

	localparam int CNT_W = $clog2(HASH_W);

	logic              run_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [HASH_W-1:0] val_q [3];
	logic [SIZE_W-1:0] rem_q [3];
	logic [SIZE_W-1:0] rem_d [3];
	logic [SIZE_W:0]   trial [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			trial[i] = {rem_q[i], val_q[i][HASH_W-1]};
			if (trial[i] >= {1'b0, size}) begin
				rem_d[i] = SIZE_W'(trial[i] - {1'b0, size});
			end else begin
				rem_d[i] = trial[i][SIZE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(HASH_W - 1)) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q[0] <= val_one;
			val_q[1] <= val_two;
			val_q[2] <= val_three;
			for (int i = 0; i < 3; i++) begin
				rem_q[i] <= '0;
			end
		end else if (run_q) begin
			for (int i = 0; i < 3; i++) begin
				val_q[i] <= val_q[i] << 1;
				rem_q[i] <= rem_d[i];
			end
		end
	end

	assign done      = run_q && (cnt_q == CNT_W'(HASH_W - 1));
	assign rem_one   = rem_q[0];
	assign rem_two   = rem_q[1];
	assign rem_three = rem_q[2];

endmodule

`default_nettype wire

// ===== rtl/thbf_bit_store.sv =====
// Filter bit store: one-bit-wide memory with one write and one read port.
// Read data is registered. No dependencies.
`default_nettype none

module thbf_bit_store #(
	parameter int DEPTH = 1024,
	localparam int AW   = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic               rd_data,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic          wr_data
);

	logic mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== verif/three_hash_bloom_filter_core_tb.sv =====
// Self-checking testbench for three_hash_bloom_filter_core with a shadow model of the filter.
// Drives key, clear and unused items and size writes; predicts all results, checks by field.
// Depends on thbf_pkg and the three_hash_bloom_filter_core RTL.
`default_nettype none

module three_hash_bloom_filter_core_tb;
	import thbf_pkg::*;

	localparam int FILTER_N = 1024;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef logic [7:0] key_bytes_t [8];

	class bloom_shadow;
		logic [HASH_W-1:0] djb_h;
		logic [HASH_W-1:0] oaat_h;
		logic [HASH_W-1:0] fnv_h;
		bit                filt [FILTER_N];
		int unsigned       cnt;
		logic [SIZE_W-1:0] size_reg;
		out_item_t         awaited [$];
		int unsigned       mismatches;

		function new();
			size_reg = 11'd1024;
			cnt = 0;
			mismatches = 0;
			foreach (filt[i]) filt[i] = 1'b0;
			reload();
		endfunction

		function void reload();
			djb_h = DJB_SEED;
			oaat_h = '0;
			fnv_h = FNV_SEED;
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction

		function void note_item(in_item_t it);
			logic [HASH_W-1:0] b;
			logic [HASH_W-1:0] mixed;
			logic [HASH_W-1:0] sz;
			logic [HASH_W-1:0] idx [3];
			bit                present;
			out_item_t         want;
			if (it.cmd == CMD_UNUSED) return;
			if (it.cmd == CMD_CLEAR) begin
				foreach (filt[i]) filt[i] = 1'b0;
				cnt = 0;
				reload();
				awaited.push_back('0);
				return;
			end
			if (it.has_byte) begin
				b = {56'd0, it.key_byte};
				djb_h = (djb_h << 5) + djb_h + b;
				oaat_h += b;
				oaat_h += oaat_h << 10;
				oaat_h ^= oaat_h >> 6;
				fnv_h ^= b;
				fnv_h *= 64'h0000_0000_0100_0193;
			end
			if (!it.last) return;
			mixed = oaat_h;
			mixed += mixed << 3;
			mixed ^= mixed >> 11;
			mixed += mixed << 15;
			if (size_reg == 0)
				sz = 64'd1;
			else if (size_reg > FILTER_N)
				sz = 64'(FILTER_N);
			else
				sz = {53'd0, size_reg};
			idx[0] = djb_h % sz;
			idx[1] = mixed % sz;
			idx[2] = fnv_h % sz;
			present = filt[idx[0][IDX_W-1:0]] && filt[idx[1][IDX_W-1:0]] &&
				filt[idx[2][IDX_W-1:0]];
			if (it.cmd == CMD_INSERT) begin
				foreach (idx[k]) begin
					if (!filt[idx[k][IDX_W-1:0]]) begin
						filt[idx[k][IDX_W-1:0]] = 1'b1;
						cnt++;
					end
				end
			end
			reload();
			want.maybe_present = present;
			want.index_one     = idx[0][IDX_W-1:0];
			want.index_two     = idx[1][IDX_W-1:0];
			want.index_three   = idx[2][IDX_W-1:0];
			want.bits_set      = cnt[SIZE_W-1:0];
			want.over_loaded   = (64'd10 * cnt) > (64'd7 * sz);
			awaited.push_back(want);
		endfunction

		function void compare(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (awaited.size() == 0) begin
				$error("result with no item awaiting it");
				mismatches++;
				return;
			end
			want = awaited.pop_front();
			compare("maybe_present", 32'(want.maybe_present), 32'(got.maybe_present));
			compare("index_one", 32'(want.index_one), 32'(got.index_one));
			compare("index_two", 32'(want.index_two), 32'(got.index_two));
			compare("index_three", 32'(want.index_three), 32'(got.index_three));
			compare("bits_set", 32'(want.bits_set), 32'(got.bits_set));
			compare("over_loaded", 32'(want.over_loaded), 32'(got.over_loaded));
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	in_item_t          item;
	logic              cfg_wen;
	logic [SIZE_W-1:0] cfg_wdata;
	logic              result_valid;
	out_item_t         result;

	bloom_shadow shadow;
	int          sent_items = 0;
	int          calm_left = 0;
	key_bytes_t  key_lib [16];
	int          key_len [16];
	int          lib_fill = 0;

	three_hash_bloom_filter_core #(
		.FILTER_BITS(FILTER_N)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.result_valid (result_valid),
		.result       (result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid)
			shadow.check_result(result);
	end

	task automatic send_item(input in_item_t it);
		int gap;
		if (calm_left > 0) begin
			gap = 0;
			calm_left--;
		end else begin
			gap = $urandom_range(0, 4);
			if ($urandom_range(0, 49) == 0)
				calm_left = $urandom_range(10, 40);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= it;
		start <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		shadow.note_item(it);
		if (it.cmd != CMD_UNUSED)
			sent_items++;
	endtask

	task automatic send_key(input key_bytes_t bytes, input int len, input logic [1:0] final_cmd);
		in_item_t it;
		bit       marker;
		marker = (len == 0) || ($urandom_range(0, 5) == 0);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				if ($urandom_range(0, 1)) begin
					it.cmd = CMD_UNUSED;
					it.has_byte = 1'($urandom);
					it.last = 1'($urandom);
				end else begin
					it.cmd = $urandom_range(0, 1) ? CMD_INSERT : CMD_QUERY;
					it.has_byte = 1'b0;
					it.last = 1'b0;
				end
				it.key_byte = 8'($urandom);
				send_item(it);
			end
			it.cmd = (i == len - 1) ? final_cmd : ($urandom_range(0, 1) ? CMD_INSERT : CMD_QUERY);
			it.key_byte = bytes[i];
			it.has_byte = 1'b1;
			it.last = (i == len - 1) && !marker;
			send_item(it);
		end
		if (marker) begin
			it.cmd = final_cmd;
			it.key_byte = 8'($urandom);
			it.has_byte = 1'b0;
			it.last = 1'b1;
			send_item(it);
		end
	endtask

	task automatic wait_for_results();
		start <= 1'b0;
		while (shadow.pending() != 0) @(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_size(input logic [SIZE_W-1:0] value);
		wait_for_results();
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		shadow.size_reg = value;
	endtask

	initial begin
		#100_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		int         roll;
		int         slot;
		int         len;
		key_bytes_t fresh;
		in_item_t   noise;
		shadow = new();
		arst_n <= 1'b0;
		start <= 1'b0;
		item <= '0;
		cfg_wen <= 1'b0;
		cfg_wdata <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		write_size(11'd1024);
		send_item(in_item_t'{CMD_INSERT, 8'hA5, 1'b0, 1'b1});
		send_item(in_item_t'{CMD_QUERY, 8'h5A, 1'b0, 1'b1});
		send_item(in_item_t'{CMD_INSERT, 8'h00, 1'b1, 1'b1});
		send_item(in_item_t'{CMD_QUERY, 8'hFF, 1'b1, 1'b1});
		send_item(in_item_t'{CMD_UNUSED, 8'h12, 1'b1, 1'b1});
		send_item(in_item_t'{CMD_QUERY, 8'h41, 1'b1, 1'b0});
		send_item(in_item_t'{CMD_UNUSED, 8'h99, 1'b1, 1'b0});
		send_item(in_item_t'{CMD_INSERT, 8'h42, 1'b0, 1'b0});
		send_item(in_item_t'{CMD_INSERT, 8'h43, 1'b1, 1'b1});
		send_item(in_item_t'{CMD_INSERT, 8'h41, 1'b1, 1'b0});
		send_item(in_item_t'{CMD_QUERY, 8'h43, 1'b1, 1'b1});
		send_item(in_item_t'{CMD_INSERT, 8'h7F, 1'b1, 1'b0});
		send_item(in_item_t'{CMD_INSERT, 8'h80, 1'b1, 1'b0});
		send_item(in_item_t'{CMD_QUERY, 8'h00, 1'b0, 1'b1});
		send_item(in_item_t'{CMD_CLEAR, 8'hFF, 1'b1, 1'b1});
		send_item(in_item_t'{CMD_QUERY, 8'hA5, 1'b0, 1'b1});
		send_item(in_item_t'{CMD_INSERT, 8'h55, 1'b1, 1'b0});
		send_item(in_item_t'{CMD_CLEAR, 8'h00, 1'b0, 1'b0});
		send_item(in_item_t'{CMD_INSERT, 8'h01, 1'b1, 1'b1});
		write_size(11'd1);
		send_item(in_item_t'{CMD_INSERT, 8'h00, 1'b0, 1'b1});
		send_item(in_item_t'{CMD_QUERY, 8'hFF, 1'b1, 1'b1});
		write_size(11'd0);
		send_item(in_item_t'{CMD_INSERT, 8'h3C, 1'b1, 1'b1});
		write_size(11'd2047);
		send_item(in_item_t'{CMD_INSERT, 8'h3C, 1'b1, 1'b1});
		send_item(in_item_t'{CMD_QUERY, 8'h3C, 1'b1, 1'b1});

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: write_size(11'($urandom_range(2, 64)));
				1: write_size(11'd1024);
				2: write_size(11'($urandom_range(0, 2047)));
				3: write_size(11'd2047);
				4: write_size(11'($urandom_range(65, 1023)));
				default: write_size(11'd1);
			endcase
			while (sent_items < 25 + (p + 1) * 310) begin
				roll = $urandom_range(0, 99);
				if (roll < 2) begin
					noise.cmd = CMD_CLEAR;
					noise.key_byte = 8'($urandom);
					noise.has_byte = 1'($urandom);
					noise.last = 1'($urandom);
					send_item(noise);
				end else if (roll < 6) begin
					noise.cmd = 2'($urandom);
					noise.key_byte = 8'($urandom);
					noise.has_byte = 1'($urandom);
					noise.last = 1'($urandom);
					send_item(noise);
					if (noise.cmd != CMD_CLEAR && noise.cmd != CMD_UNUSED && !noise.last) begin
						noise.cmd = $urandom_range(0, 1) ? CMD_INSERT : CMD_QUERY;
						noise.has_byte = 1'b0;
						noise.last = 1'b1;
						send_item(noise);
					end
				end else if (roll < 7) begin
					wait_for_results();
				end else if (roll < 30 && lib_fill > 0) begin
					slot = $urandom_range(0, lib_fill - 1);
					send_key(key_lib[slot], key_len[slot],
						$urandom_range(0, 2) == 0 ? CMD_INSERT : CMD_QUERY);
				end else begin
					len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
					foreach (fresh[i]) fresh[i] = 8'($urandom);
					if (lib_fill < 16) begin
						slot = lib_fill;
						lib_fill++;
					end else begin
						slot = $urandom_range(0, 15);
					end
					key_lib[slot] = fresh;
					key_len[slot] = len;
					send_key(fresh, len, $urandom_range(0, 4) < 3 ? CMD_INSERT : CMD_QUERY);
				end
			end
		end

		wait_for_results();
		if (shadow.mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/thbf_pkg.sv
rtl/thbf_hash_alu.sv
rtl/thbf_mod_unit.sv
rtl/thbf_bit_store.sv
rtl/three_hash_bloom_filter_core.sv
verif/three_hash_bloom_filter_core_tb.sv
